FILE: design/nmis_pkg.sv
// Shared types and codes for the nested medium identifier stack.
package nmis_pkg;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH,
		S_SHIFT,
		S_TOPRD,
		S_TOPCAP
	} state_t;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_DUP     = 2'd1;
	localparam status_t ST_FULL    = 2'd2;
	localparam status_t ST_MISSING = 2'd3;

	localparam logic KIND_ENTER = 1'b0;

endpackage

FILE: design/nested_medium_id_stack_top.sv
// Nested medium identifier stack: each input transfer runs a search that compares the stored
// slots in turn from the bottom; a removal then moves every slot above the removed one down one
// place; last the top slot is read for the result. A rejected enter on a full stack skips the
// search. One item is worked at a time; the input is free again from the cycle in which a result
// is offered on out_valid.
// The output register lets the next item be taken while a result waits to transfer.
// Reset empties the stack at once; the slot memory itself is not cleared.
module nested_medium_id_stack_top
	import nmis_pkg::*;
#(
	parameter int STACK_DEPTH = 8,
	parameter int ID_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [7:0] medium_id,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [3:0] depth,
	output logic       top_valid,
	output logic [7:0] top_id
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int KW = ID_BITS + 8;

	logic               busy;
	logic               start;
	logic [KW-1:0]      id_wide;
	logic [ID_BITS-1:0] key;
	logic               res_ready;
	logic               res_valid;
	status_t            res_status;
	logic [CW-1:0]      res_count;
	logic               res_top_valid;
	logic [ID_BITS-1:0] res_top_id;
	logic [KW-1:0]      top_wide;
	logic [CW+3:0]      cnt_wide;
	logic               mem_wen;
	logic [AW-1:0]      mem_waddr;
	logic [ID_BITS-1:0] mem_wdata;
	logic [AW-1:0]      mem_raddr;
	logic [ID_BITS-1:0] mem_rdata;

	logic               out_valid_q;
	status_t            status_q;
	logic [3:0]         depth_q;
	logic               top_valid_q;
	logic [7:0]         top_id_q;

	assign in_stall = busy;
	assign start    = in_valid && !busy;
	assign id_wide  = KW'(medium_id);
	assign key      = id_wide[ID_BITS-1:0];

	nmis_mem #(
		.STACK_DEPTH(STACK_DEPTH),
		.AW(AW),
		.W(ID_BITS)
	) u_mem (
		.clk(clk),
		.wen(mem_wen),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	nmis_seq #(
		.STACK_DEPTH(STACK_DEPTH),
		.ID_BITS(ID_BITS),
		.AW(AW),
		.CW(CW)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.start_kind(kind),
		.start_key(key),
		.busy(busy),
		.res_ready(res_ready),
		.res_valid(res_valid),
		.res_status(res_status),
		.res_count(res_count),
		.res_top_valid(res_top_valid),
		.res_top_id(res_top_id),
		.mem_wen(mem_wen),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	assign res_ready = !out_valid_q || !out_stall;
	assign top_wide  = KW'(res_top_id);
	assign cnt_wide  = (CW + 4)'(res_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			status_q    <= res_status;
			depth_q     <= cnt_wide[3:0];
			top_valid_q <= res_top_valid;
			top_id_q    <= res_top_valid ? top_wide[7:0] : 8'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign depth     = depth_q;
	assign top_valid = top_valid_q;
	assign top_id    = top_id_q;

endmodule

FILE: design/nmis_mem.sv
// Stack slot memory: one write port and one registered read port.
module nmis_mem
	import nmis_pkg::*;
#(
	parameter int STACK_DEPTH = 8,
	parameter int AW = 3,
	parameter int W = 8
) (
	input  logic          clk,
	input  logic          wen,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/nmis_seq.sv
// Sequencer with the shared identifier comparator: search, compaction and top read.
module nmis_seq
	import nmis_pkg::*;
#(
	parameter int STACK_DEPTH = 8,
	parameter int ID_BITS = 8,
	parameter int AW = 3,
	parameter int CW = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               start_kind,
	input  logic [ID_BITS-1:0] start_key,
	output logic               busy,
	input  logic               res_ready,
	output logic               res_valid,
	output status_t            res_status,
	output logic [CW-1:0]      res_count,
	output logic               res_top_valid,
	output logic [ID_BITS-1:0] res_top_id,
	output logic               mem_wen,
	output logic [AW-1:0]      mem_waddr,
	output logic [ID_BITS-1:0] mem_wdata,
	output logic [AW-1:0]      mem_raddr,
	input  logic [ID_BITS-1:0] mem_rdata
);

	localparam logic [CW-1:0] CntMax = CW'(STACK_DEPTH);

	state_t             state_q, state_d;
	logic               kind_q, kind_d;
	logic [ID_BITS-1:0] key_q, key_d;
	logic [CW-1:0]      cnt_q, cnt_d;
	logic [CW-1:0]      ptr_q, ptr_d;
	logic               pend_q, pend_d;
	logic [AW-1:0]      pidx_q, pidx_d;
	status_t            status_q, status_d;
	logic               hit;
	logic [CW-1:0]      ptr_dec;
	logic [CW-1:0]      cnt_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q   <= kind_d;
		key_q    <= key_d;
		ptr_q    <= ptr_d;
		pidx_q   <= pidx_d;
		status_q <= status_d;
	end

	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		key_d     = key_q;
		cnt_d     = cnt_q;
		ptr_d     = ptr_q;
		pend_d    = pend_q;
		pidx_d    = pidx_q;
		status_d  = status_q;
		mem_wen   = 1'b0;
		mem_waddr = pidx_q;
		mem_wdata = key_q;
		mem_raddr = ptr_q[AW-1:0];
		res_valid = 1'b0;
		ptr_dec   = ptr_q - CW'(1);
		cnt_dec   = cnt_q - CW'(1);
		// Read data is registered, so pend marks a slot whose data is under compare.
		hit       = pend_q && (mem_rdata == key_q);

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					kind_d = start_kind;
					key_d  = start_key;
					ptr_d  = '0;
					pend_d = 1'b0;
					if (start_kind == KIND_ENTER && cnt_q == CntMax) begin
						status_d = ST_FULL;
						state_d  = S_TOPRD;
					end else begin
						state_d = S_SRCH;
					end
				end
			end
			S_SRCH: begin
				if (hit) begin
					if (kind_q == KIND_ENTER) begin
						status_d = ST_DUP;
						state_d  = S_TOPRD;
					end else begin
						// Entries are unique, so the single match is the one to remove.
						ptr_d   = CW'(pidx_q) + CW'(1);
						pend_d  = 1'b0;
						state_d = S_SHIFT;
					end
				end else if (!pend_q && ptr_q == cnt_q) begin
					if (kind_q == KIND_ENTER) begin
						mem_wen   = 1'b1;
						mem_waddr = cnt_q[AW-1:0];
						mem_wdata = key_q;
						cnt_d     = cnt_q + CW'(1);
						status_d  = ST_OK;
					end else begin
						status_d = ST_MISSING;
					end
					state_d = S_TOPRD;
				end else if (ptr_q != cnt_q) begin
					ptr_d  = ptr_q + CW'(1);
					pend_d = 1'b1;
					pidx_d = ptr_q[AW-1:0];
				end else begin
					pend_d = 1'b0;
				end
			end
			S_SHIFT: begin
				if (pend_q) begin
					mem_wen   = 1'b1;
					mem_waddr = pidx_q;
					mem_wdata = mem_rdata;
				end
				if (ptr_q != cnt_q) begin
					pidx_d = ptr_dec[AW-1:0];
					ptr_d  = ptr_q + CW'(1);
					pend_d = 1'b1;
				end else begin
					pend_d = 1'b0;
					if (!pend_q) begin
						cnt_d    = cnt_dec;
						status_d = ST_OK;
						state_d  = S_TOPRD;
					end
				end
			end
			S_TOPRD: begin
				mem_raddr = cnt_dec[AW-1:0];
				state_d   = S_TOPCAP;
			end
			S_TOPCAP: begin
				// Keep the top address so the read data holds while the output is busy.
				mem_raddr = cnt_dec[AW-1:0];
				if (res_ready) begin
					res_valid = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy          = (state_q != S_IDLE);
	assign res_status    = status_q;
	assign res_count     = cnt_q;
	assign res_top_valid = (cnt_q != '0);
	assign res_top_id    = mem_rdata;

endmodule

FILE: verif/nested_medium_id_stack_top_tb.sv
// Self-checking testbench for the nested medium identifier stack.
module nested_medium_id_stack_top_tb
	import nmis_pkg::*;
();

	localparam int STACK_SLOTS = 8;
	localparam int HANG_LIMIT = 2000;
	localparam int MAX_SHOWN = 40;
	localparam logic KIND_LEAVE = ~KIND_ENTER;

	typedef struct packed {
		status_t    status;
		logic [3:0] depth;
		logic       top_valid;
		logic [7:0] top_id;
	} stack_view_t;

	class medium_stack_scoreboard;
		logic [7:0] slots [STACK_SLOTS];
		int fill;
		stack_view_t pending_views [$];
		int errors;
		int status_seen [4];
		int deepest;
		int inner_removals;

		function new();
			fill = 0;
			errors = 0;
			deepest = 0;
			inner_removals = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function int pending();
			return pending_views.size();
		endfunction

		// Applies one accepted item to the stack copy and queues the result it must give.
		function void note_transfer(logic k, logic [7:0] id);
			stack_view_t v;
			int pos;
			int j;
			if (k == KIND_ENTER) begin
				if (fill >= STACK_SLOTS) begin
					v.status = ST_FULL;
				end else begin
					v.status = ST_OK;
					for (j = 0; j < fill; j++)
						if (slots[j] == id) v.status = ST_DUP;
					if (v.status == ST_OK) begin
						slots[fill] = id;
						fill++;
					end
				end
			end else begin
				pos = -1;
				for (j = fill - 1; j >= 0 && pos < 0; j--)
					if (slots[j] == id) pos = j;
				if (pos < 0) begin
					v.status = ST_MISSING;
				end else begin
					if (pos != fill - 1) inner_removals++;
					for (j = pos; j < fill - 1; j++) slots[j] = slots[j + 1];
					fill--;
					v.status = ST_OK;
				end
			end
			v.depth = fill[3:0];
			v.top_valid = (fill > 0);
			v.top_id = (fill > 0) ? slots[fill - 1] : 8'd0;
			if (fill > deepest) deepest = fill;
			status_seen[v.status]++;
			pending_views.push_back(v);
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= MAX_SHOWN) $display("mismatch %0d: %s", errors, what);
		endtask

		task check_result(status_t st, logic [3:0] d, logic tv, logic [7:0] tid);
			stack_view_t e;
			if (pending_views.size() == 0) begin
				report_mismatch("result transfer with no item outstanding");
				return;
			end
			e = pending_views.pop_front();
			if (st !== e.status)
				report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
			if (d !== e.depth)
				report_mismatch($sformatf("depth %0d, expected %0d", d, e.depth));
			if (tv !== e.top_valid)
				report_mismatch($sformatf("top_valid %0b, expected %0b", tv, e.top_valid));
			if (tid !== e.top_id)
				report_mismatch($sformatf("top_id 0x%02h, expected 0x%02h", tid, e.top_id));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic kind;
	logic [7:0] medium_id;
	logic out_valid;
	logic out_stall = 1'b0;
	status_t status;
	logic [3:0] depth;
	logic top_valid;
	logic [7:0] top_id;

	medium_stack_scoreboard sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;
	int quiet_cycles = 0;

	nested_medium_id_stack_top #(
		.STACK_DEPTH(STACK_SLOTS),
		.ID_BITS(8)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.medium_id(medium_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.depth(depth),
		.top_valid(top_valid),
		.top_id(top_id)
	);

	always #6 clk = ~clk;

	// Result side: check each transfer, then pick the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, depth, top_valid, top_id);
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= HANG_LIMIT) begin
			$display("no transfer for %0d cycles, %0d results outstanding",
				HANG_LIMIT, sb.pending());
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(input logic k, input logic [7:0] id);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		medium_id <= id;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_transfer(k, id);
		items_sent++;
	endtask

	// Holds the input side off until every outstanding result has transferred.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic run_random_phase(input int n, input int sidle, input int rstall);
		logic [7:0] pool [12];
		int i;
		int r;
		int enter_bias;
		logic k;
		logic [7:0] id;
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		enter_bias = 70;
		for (i = 0; i < n; i++) begin
			// Fresh identifiers now and then; swing between filling and emptying.
			if (i % 100 == 0)
				foreach (pool[j]) pool[j] = 8'($urandom_range(0, 255));
			if (i % 40 == 0)
				enter_bias = (enter_bias == 70) ? 35 : 70;
			r = $urandom_range(0, 99);
			if (r < 10) begin
				k = 1'($urandom_range(0, 1));
				id = 8'($urandom_range(0, 255));
			end else begin
				k = ($urandom_range(0, 99) < enter_bias) ? KIND_ENTER : KIND_LEAVE;
				id = pool[$urandom_range(0, 11)];
			end
			send_item(k, id);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_ENTER;
		medium_id = 8'd0;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 35;
		recv_stall_pct = 59;
		// Exit on an empty stack, extremes of the identifier, a duplicate, a full stack
		// (also with an identifier already present), then removals from the middle,
		// the top and the bottom, and an exit of an identifier that is not there.
		send_item(KIND_LEAVE, 8'h5a);
		send_item(KIND_ENTER, 8'h00);
		send_item(KIND_ENTER, 8'hff);
		send_item(KIND_ENTER, 8'hff);
		send_item(KIND_ENTER, 8'h01);
		send_item(KIND_ENTER, 8'h80);
		send_item(KIND_ENTER, 8'h7f);
		send_item(KIND_ENTER, 8'haa);
		send_item(KIND_ENTER, 8'h55);
		send_item(KIND_ENTER, 8'h10);
		send_item(KIND_ENTER, 8'h00);
		send_item(KIND_ENTER, 8'h33);
		send_item(KIND_LEAVE, 8'h7f);
		send_item(KIND_LEAVE, 8'h10);
		send_item(KIND_LEAVE, 8'h00);
		send_item(KIND_LEAVE, 8'h99);
		send_item(KIND_LEAVE, 8'hff);
		send_item(KIND_LEAVE, 8'h01);
		send_item(KIND_LEAVE, 8'h80);
		send_item(KIND_LEAVE, 8'haa);
		send_item(KIND_LEAVE, 8'h55);
		send_item(KIND_LEAVE, 8'h55);
		drain_results();

		run_random_phase(260, 35, 59);
		drain_results();
		run_random_phase(260, 59, 35);
		drain_results();
		run_random_phase(280, 0, 0);

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (2 * STACK_SLOTS + 10) @(posedge clk);

		$display("Covered %0d items: %0d accepted, %0d duplicates, %0d full rejects, %0d misses.",
			items_sent, sb.status_seen[ST_OK], sb.status_seen[ST_DUP],
			sb.status_seen[ST_FULL], sb.status_seen[ST_MISSING]);
		$display("Deepest stack %0d, %0d removals below the top, %0d mismatches.",
			sb.deepest, sb.inner_removals, sb.errors);
		if (sb.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

FILE: sim.f
design/nmis_pkg.sv
design/nmis_mem.sv
design/nmis_seq.sv
design/nested_medium_id_stack_top.sv
verif/nested_medium_id_stack_top_tb.sv
